FILE: rtl/dbb_pkg.sv
// Shared constants for the dual-source bilinear blend: the interpolation weight ROM,
// the configuration register indexes and the pipeline depths.
// No dependencies; every other file but dbb_chk imports this package.
package dbb_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_OFS   = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_APPLY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS0  = 3'd1;

    // Register stages in one source lane and in one blend channel.
    localparam int LANE_LAT  = 3;
    localparam int BLEND_LAT = 4;
    localparam int PIPE_LAT  = LANE_LAT + BLEND_LAT + 1;

    // Output values of a blank pixel.
    localparam logic [PIX_W-1:0] BLANK_LUMA   = 8'd0;
    localparam logic [PIX_W-1:0] BLANK_CHROMA = 8'd128;

    // Four byte weights per entry, top-left in bits 31:24 down to diagonal in 7:0.
    // Addressed by {frac_x, frac_y}.
    localparam logic [31:0] INTERP_ROM [64] = '{
        32'd2147483648, 32'd1828721152, 32'd1526735872, 32'd1224750592,
        32'd905988352,  32'd604003072,  32'd302017792,  32'd32768,
        32'd1829896192, 32'd1578045186, 32'd1309482757, 32'd1040854791,
        32'd789003786,  32'd520441357,  32'd251813391,  32'd27922,
        32'd1529085952, 32'd1310657797, 32'd1092229642, 32'd873735951,
        32'd655307796,  32'd436879642,  32'd218451487,  32'd23332,
        32'd1228275712, 32'd1043270151, 32'd874976271,  32'd689905431,
        32'd521611551,  32'd336540711,  32'd168246831,  32'd18742,
        32'd910753792,  32'd792594186,  32'd657723156,  32'd522786591,
        32'd387915561,  32'd252978996,  32'd118107966,  32'd13897,
        32'd609943552,  32'd525206797,  32'd440470042,  32'd338956071,
        32'd254219316,  32'd169482817,  32'd84746062,   32'd9307,
        32'd309133312,  32'd257819151,  32'd223216927,  32'd171837231,
        32'd120523326,  32'd85921102,   32'd34541406,   32'd4717,
        32'd8388608,    32'd7143442,    32'd5963812,    32'd4784182,
        32'd3539017,    32'd2359387,    32'd1179757,    32'd128
    };

endpackage

FILE: rtl/dbb_src_lane.sv
// One source lane: bilinear luma interpolation from the weight ROM, followed by the
// optional per-camera offset and clamp. Three register stages.
// Depends on dbb_pkg.
module dbb_src_lane
    import dbb_pkg::*;
#(
    parameter int NUM_OFS = 4
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_apply,
    input  logic signed [PIX_W-1:0] i_luma_ofs [NUM_OFS],
    input  logic [2:0]              i_frac_x,
    input  logic [2:0]              i_frac_y,
    input  logic [31:0]             i_luma_quad,
    input  logic [1:0]              i_camera,
    output logic [PIX_W-1:0]        o_luma
);

    logic [31:0]             r_wt;
    logic [31:0]             r_quad;
    logic signed [PIX_W-1:0] r_ofs1;
    logic signed [PIX_W-1:0] r_ofs2;
    logic signed [PIX_W-1:0] n_ofs;
    logic [15:0]             r_prod [4];
    logic [17:0]             n_sum;
    logic [10:0]             n_int;
    logic signed [12:0]      n_adj;
    logic [PIX_W-1:0]        n_luma;
    logic [PIX_W-1:0]        r_luma;

    // Offset of the source camera; a camera without an offset register gets zero.
    always_comb begin
        n_ofs = '0;
        for (int k = 0; k < NUM_OFS; k++) begin
            if (i_camera == 2'(k)) begin
                n_ofs = i_luma_ofs[k];
            end
        end
    end

    // Stage 1: weight ROM lookup.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wt   <= INTERP_ROM[{i_frac_x, i_frac_y}];
            r_quad <= i_luma_quad;
            r_ofs1 <= n_ofs;
        end
    end

    // Stage 2: one 8x8 product per neighbour.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= 16'(r_quad[8*(3-k) +: 8]) * 16'(r_wt[8*(3-k) +: 8]);
            end
            r_ofs2 <= r_ofs1;
        end
    end

    // Stage 3: sum, scale down by 128, then offset and clamp when enabled.
    always_comb begin
        n_sum = 18'(r_prod[0]) + 18'(r_prod[1]) + 18'(r_prod[2]) + 18'(r_prod[3]);
        n_int = n_sum[17:7];
        n_adj = $signed({2'b00, n_int}) + 13'(r_ofs2);
        if (!i_apply) begin
            n_luma = n_int[7:0];
        end else if (n_adj < 0) begin
            n_luma = '0;
        end else if (n_adj > 13'sd255) begin
            n_luma = '1;
        end else begin
            n_luma = n_adj[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_luma <= n_luma;
        end
    end

    assign o_luma = r_luma;

endmodule

FILE: rtl/dbb_blend_ch.sv
// One blend channel: (wa*a + (MAX-wa)*b) / MAX with truncation. The division by the
// constant is a reciprocal multiply with a single correction step. Four register stages.
// Depends on dbb_pkg.
module dbb_blend_ch
    import dbb_pkg::*;
#(
    parameter int BLEND_MAX = 255
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [PIX_W-1:0] i_wa,
    input  logic [PIX_W-1:0] i_a,
    input  logic [PIX_W-1:0] i_b,
    output logic [PIX_W-1:0] o_q
);

    localparam int          RECIP_SH = 25;
    localparam logic [25:0] RECIP    = 26'((64'd1 << RECIP_SH) / BLEND_MAX);
    localparam logic [7:0]  MAX8     = 8'(BLEND_MAX);

    logic [15:0]      r_pa;
    logic [15:0]      r_pb;
    logic [16:0]      r_num2;
    logic [16:0]      r_num3;
    logic [16:0]      r_num4;
    logic [42:0]      n_prod;
    logic [PIX_W-1:0] r_q03;
    logic [PIX_W-1:0] r_q04;
    logic [16:0]      r_qm;
    logic [16:0]      n_rem;

    // Stage 1: the two weighted terms.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= 16'(i_wa) * 16'(i_a);
            r_pb <= 16'(MAX8 - i_wa) * 16'(i_b);
        end
    end

    // Stage 2: numerator.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num2 <= 17'(r_pa) + 17'(r_pb);
        end
    end

    // Stage 3: quotient estimate, equal to the true quotient or one below it.
    assign n_prod = 43'(r_num2) * 43'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q03  <= n_prod[RECIP_SH +: PIX_W];
            r_num3 <= r_num2;
        end
    end

    // Stage 4: back-multiply the estimate.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qm   <= 17'(r_q03) * 17'(MAX8);
            r_q04  <= r_q03;
            r_num4 <= r_num3;
        end
    end

    // Correction: a remainder of at least MAX means the estimate was one short.
    assign n_rem = r_num4 - r_qm;
    assign o_q   = (n_rem >= 17'(MAX8)) ? r_q04 + 8'd1 : r_q04;

endmodule

FILE: rtl/dual_source_bilinear_blend.sv
// Dual-source bilinear blend: one output pixel per transaction from two camera sources.
// Top level; depends on dbb_pkg, dbb_src_lane and dbb_blend_ch.
//
// The block accepts one pixel per clock unless a result waits on a stalled output; each
// result takes exactly one input transaction. The two source lanes (3 stages: ROM,
// products, sum with offset and clamp) run side by side, and three blend channels
// (4 stages: products, sum, reciprocal multiply, back-multiply with correction) merge
// luma, U and V before the output register. The whole pipeline holds while a result
// waits on a stalled output, so o_stall is high only then. Configuration writes are
// always ready and must be made while no pixel is in flight.
module dual_source_bilinear_blend
    import dbb_pkg::*;
#(
    parameter int BLEND_MAX = 255,
    parameter int CAMERAS   = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data,
    // Input pixel channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_blank,
    input  logic [7:0]           i_blend_weight,
    input  logic [2:0]           i_frac_x_a,
    input  logic [2:0]           i_frac_y_a,
    input  logic [31:0]          i_luma_quad_a,
    input  logic [15:0]          i_chroma_a,
    input  logic [1:0]           i_camera_a,
    input  logic [2:0]           i_frac_x_b,
    input  logic [2:0]           i_frac_y_b,
    input  logic [31:0]          i_luma_quad_b,
    input  logic [15:0]          i_chroma_b,
    input  logic [1:0]           i_camera_b,
    // Output pixel channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_luma_out,
    output logic [7:0]           o_cb_out,
    output logic [7:0]           o_cr_out
);

    localparam int NUM_OFS = (CAMERAS < MAX_OFS) ? CAMERAS : MAX_OFS;
    localparam logic [7:0] MAX8 = 8'(BLEND_MAX);

    logic                    r_apply;
    logic signed [PIX_W-1:0] r_luma_ofs [NUM_OFS];
    logic                    en;
    logic                    r_vld [PIPE_LAT];
    logic                    r_blank_d [PIPE_LAT-1];
    logic [PIX_W-1:0]        r_wa_d [LANE_LAT];
    logic [15:0]             r_cha_d [LANE_LAT];
    logic [15:0]             r_chb_d [LANE_LAT];
    logic [PIX_W-1:0]        n_wa;
    logic [PIX_W-1:0]        ya;
    logic [PIX_W-1:0]        yb;
    logic [PIX_W-1:0]        q_y;
    logic [PIX_W-1:0]        q_u;
    logic [PIX_W-1:0]        q_v;
    logic [PIX_W-1:0]        r_luma_out;
    logic [PIX_W-1:0]        r_cb_out;
    logic [PIX_W-1:0]        r_cr_out;

    // Configuration registers; every write is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apply <= 1'b0;
            for (int k = 0; k < NUM_OFS; k++) begin
                r_luma_ofs[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_APPLY) begin
                r_apply <= i_cfg_data[0];
            end
            for (int k = 0; k < NUM_OFS; k++) begin
                if (i_cfg_index == CFG_IDX_W'(CFG_OFS0 + k)) begin
                    r_luma_ofs[k] <= i_cfg_data;
                end
            end
        end
    end

    // The pipeline advances unless the output holds a result that is stalled.
    assign en      = !(r_vld[PIPE_LAT-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < PIPE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Weights above the maximum saturate, leaving source B nothing.
    assign n_wa = (i_blend_weight > MAX8) ? MAX8 : i_blend_weight;

    // Side data travels alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_blank_d[0] <= i_blank;
            for (int k = 1; k < PIPE_LAT - 1; k++) begin
                r_blank_d[k] <= r_blank_d[k-1];
            end
            r_wa_d[0]  <= n_wa;
            r_cha_d[0] <= i_chroma_a;
            r_chb_d[0] <= i_chroma_b;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_wa_d[k]  <= r_wa_d[k-1];
                r_cha_d[k] <= r_cha_d[k-1];
                r_chb_d[k] <= r_chb_d[k-1];
            end
        end
    end

    // Source lanes.
    dbb_src_lane #(.NUM_OFS(NUM_OFS)) u_lane_a (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_apply     (r_apply),
        .i_luma_ofs  (r_luma_ofs),
        .i_frac_x    (i_frac_x_a),
        .i_frac_y    (i_frac_y_a),
        .i_luma_quad (i_luma_quad_a),
        .i_camera    (i_camera_a),
        .o_luma      (ya)
    );

    dbb_src_lane #(.NUM_OFS(NUM_OFS)) u_lane_b (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_apply     (r_apply),
        .i_luma_ofs  (r_luma_ofs),
        .i_frac_x    (i_frac_x_b),
        .i_frac_y    (i_frac_y_b),
        .i_luma_quad (i_luma_quad_b),
        .i_camera    (i_camera_b),
        .o_luma      (yb)
    );

    // Merge: blend luma, U and V of the two sources.
    dbb_blend_ch #(.BLEND_MAX(BLEND_MAX)) u_blend_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_wa  (r_wa_d[LANE_LAT-1]),
        .i_a   (ya),
        .i_b   (yb),
        .o_q   (q_y)
    );

    dbb_blend_ch #(.BLEND_MAX(BLEND_MAX)) u_blend_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_wa  (r_wa_d[LANE_LAT-1]),
        .i_a   (r_cha_d[LANE_LAT-1][15:8]),
        .i_b   (r_chb_d[LANE_LAT-1][15:8]),
        .o_q   (q_u)
    );

    dbb_blend_ch #(.BLEND_MAX(BLEND_MAX)) u_blend_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_wa  (r_wa_d[LANE_LAT-1]),
        .i_a   (r_cha_d[LANE_LAT-1][7:0]),
        .i_b   (r_chb_d[LANE_LAT-1][7:0]),
        .o_q   (q_v)
    );

    // Output register; a blank pixel is forced to black.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_blank_d[PIPE_LAT-2]) begin
                r_luma_out <= BLANK_LUMA;
                r_cb_out   <= BLANK_CHROMA;
                r_cr_out   <= BLANK_CHROMA;
            end else begin
                r_luma_out <= q_y;
                r_cb_out   <= q_u;
                r_cr_out   <= q_v;
            end
        end
    end

    assign o_valid    = r_vld[PIPE_LAT-1];
    assign o_luma_out = r_luma_out;
    assign o_cb_out   = r_cb_out;
    assign o_cr_out   = r_cr_out;

endmodule

FILE: rtl/dbb_chk.sv
// Port-level checker for dual_source_bilinear_blend, with the bind that attaches it.
// Depends only on the top level's port list.
module dbb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_luma_out,
    input logic [7:0] o_cb_out,
    input logic [7:0] o_cr_out
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_luma_out) && $stable(o_cb_out)
                                   && $stable(o_cr_out)))
        else $error("stalled output transaction changed");

    // Input is held back only when a finished result is itself stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output transaction");

    // When no result is stalled, a new input transaction is always taken.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while output is free");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output transaction valid after reset");

endmodule

bind dual_source_bilinear_blend dbb_chk u_dbb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_luma_out  (o_luma_out),
    .o_cb_out    (o_cb_out),
    .o_cr_out    (o_cr_out)
);
